### src/ami_pkg.sv
`default_nettype none
// ============================================================================
// ami_pkg: shared types and constants for the affine matrix inverse
// Word formats, intermediate widths and row codes used by all modules.
// ============================================================================
package ami_pkg;

    // Signed fixed-point word and its fraction bits.
    localparam int W  = 32;
    localparam int F  = 16;

    // Intermediate widths: product, adjugate entry, determinant/translation.
    localparam int PW = 2 * W;
    localparam int AW = 2 * W + 1;
    localparam int DW = 3 * W + 3;

    // Divider widths: shifted numerator magnitude, quotient bits, compare width.
    localparam int NW = DW + F;
    localparam int QB = W;
    localparam int CW = DW + QB;

    // Threshold register.
    localparam int TW = 17;
    localparam logic [TW-1:0] THR_RESET = TW'(7);

    // Result rows.
    localparam int RB = 2;
    localparam logic [RB-1:0] ROW_0    = RB'(0);
    localparam logic [RB-1:0] ROW_1    = RB'(1);
    localparam logic [RB-1:0] ROW_2    = RB'(2);
    localparam logic [RB-1:0] ROW_LAST = RB'(3);

    // Pipeline depths.
    localparam int FS = 7;
    localparam int DS = QB + 3;

    typedef logic signed [W-1:0]  t_word;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [AW-1:0] t_adj;
    typedef logic signed [DW-1:0] t_wide;

    typedef struct packed {
        logic [RB-1:0] row;
        logic          last;
        logic          sing;
    } t_meta;

endpackage
`default_nettype wire

### src/ami_cofactor.sv
`default_nettype none
// ============================================================================
// ami_cofactor: adjugate, determinant and inverse translation numerators
// Seven register stages; exact arithmetic, multipliers split to 33x32.
// ============================================================================
module ami_cofactor (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  ami_pkg::t_word          i_s [4][3],
    input  logic [ami_pkg::TW-1:0]  i_threshold,
    output logic                    o_valid,
    output ami_pkg::t_adj           o_adj [3][3],
    output ami_pkg::t_wide          o_tr [3],
    output ami_pkg::t_wide          o_det,
    output logic                    o_sing
);
    import ami_pkg::*;

    logic [FS-1:0] r_v;

    t_word r_s1 [4][3];
    t_prod r_p1 [3][3];
    t_prod r_p2 [3][3];
    t_word r_r0_2 [3];
    t_word r_r3_2 [3];
    t_adj  r_adj3 [3][3];
    t_word r_r0_3 [3];
    t_word r_r3_3 [3];
    t_adj  r_dh [3];
    t_adj  r_dl [3];
    t_adj  r_th [3][3];
    t_adj  r_tl [3][3];
    t_adj  r_adj4 [3][3];
    t_wide r_dp [3];
    t_wide r_tp [3][3];
    t_adj  r_adj5 [3][3];
    t_wide r_det6;
    t_wide r_tr6 [3];
    t_adj  r_adj6 [3][3];
    t_wide r_det7;
    t_wide r_tr7 [3];
    t_adj  r_adj7 [3][3];
    logic  r_sing7;

    logic [DW-1:0] det_mag;
    logic [DW-1:0] thr_wide;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[FS-2:0], i_valid};
        end
    end

    // Stage 1: input capture.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= i_s;
        end
    end

    // Stages 2 and 3: cofactor products and differences.
    for (genvar i = 0; i < 3; i++) begin : g_adj_r
        for (genvar j = 0; j < 3; j++) begin : g_adj_c
            localparam int J1 = (j + 1) % 3;
            localparam int J2 = (j + 2) % 3;
            localparam int I1 = (i + 1) % 3;
            localparam int I2 = (i + 2) % 3;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_p1[i][j]   <= t_prod'(r_s1[J1][I1]) * t_prod'(r_s1[J2][I2]);
                    r_p2[i][j]   <= t_prod'(r_s1[J1][I2]) * t_prod'(r_s1[J2][I1]);
                    r_adj3[i][j] <= t_adj'(r_p1[i][j]) - t_adj'(r_p2[i][j]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r0_2 <= r_s1[0];
            r_r3_2 <= r_s1[3];
            r_r0_3 <= r_r0_2;
            r_r3_3 <= r_r3_2;
            r_adj4 <= r_adj3;
            r_adj5 <= r_adj4;
            r_adj6 <= r_adj5;
            r_adj7 <= r_adj6;
        end
    end

    // Stages 4 and 5: each 65x32 product is split into a high 33x32 and a
    // low 33x32 partial product, then recombined.
    for (genvar k = 0; k < 3; k++) begin : g_pp
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dh[k] <= t_adj'($signed(r_adj3[k][0][AW-1:W])) * t_adj'(r_r0_3[k]);
                r_dl[k] <= t_adj'($signed({1'b0, r_adj3[k][0][W-1:0]})) * t_adj'(r_r0_3[k]);
                r_dp[k] <= (t_wide'(r_dh[k]) <<< W) + t_wide'(r_dl[k]);
            end
        end
        for (genvar j = 0; j < 3; j++) begin : g_ppt
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_th[k][j] <= t_adj'($signed(r_adj3[k][j][AW-1:W])) * t_adj'(r_r3_3[k]);
                    r_tl[k][j] <= t_adj'($signed({1'b0, r_adj3[k][j][W-1:0]}))
                                  * t_adj'(r_r3_3[k]);
                    r_tp[k][j] <= (t_wide'(r_th[k][j]) <<< W) + t_wide'(r_tl[k][j]);
                end
            end
        end
    end

    // Stage 6: sums. Stage 7: singular test against the threshold.
    assign det_mag  = r_det6[DW-1] ? DW'(-r_det6) : DW'(r_det6);
    assign thr_wide = DW'(i_threshold) << (2 * F);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_det6 <= r_dp[0] + r_dp[1] + r_dp[2];
            for (int j = 0; j < 3; j++) begin
                r_tr6[j] <= -(r_tp[0][j] + r_tp[1][j] + r_tp[2][j]);
            end
            r_det7  <= r_det6;
            r_tr7   <= r_tr6;
            r_sing7 <= det_mag <= thr_wide;
        end
    end

    assign o_valid = r_v[FS-1];
    assign o_adj   = r_adj7;
    assign o_tr    = r_tr7;
    assign o_det   = r_det7;
    assign o_sing  = r_sing7;

endmodule
`default_nettype wire

### src/ami_div_lane.sv
`default_nettype none
// ============================================================================
// ami_div_lane: pipelined fixed-point divider for one result column
// Restoring division, one quotient bit per stage, round and saturate.
// ============================================================================
module ami_div_lane (
    input  logic            i_clk,
    input  logic            i_en,
    input  ami_pkg::t_wide  i_num,
    input  ami_pkg::t_wide  i_den,
    input  logic            i_is_tr,
    output ami_pkg::t_word  o_quo
);
    import ami_pkg::*;

    localparam logic [W:0] LIM   = (W+1)'(1) << (W - 1);
    localparam logic [W:0] MAXP  = LIM - (W+1)'(1);

    logic [DW-1:0] num_mag;
    logic [DW-1:0] den_mag;
    logic [NW-1:0] n_shift;

    logic [NW-1:0] r_n0;
    logic [DW-1:0] r_d0;
    logic          r_neg0;

    logic [NW-1:0] r_rem [QB+1];
    logic [DW-1:0] r_den [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic          r_neg [QB+1];
    logic          r_ovf [QB+1];

    logic          rnd;
    logic [W:0]    q_full;
    t_word         n_quo;
    t_word         r_quo;

    assign num_mag = i_num[DW-1] ? DW'(-i_num) : DW'(i_num);
    assign den_mag = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
    assign n_shift = i_is_tr ? (NW'(num_mag) << F) : (NW'(num_mag) << (2 * F));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n0   <= n_shift;
            r_d0   <= den_mag;
            r_neg0 <= i_num[DW-1] ^ i_den[DW-1];
            // A quotient of 2^W or more saturates either way.
            r_rem[0] <= r_n0;
            r_den[0] <= r_d0;
            r_q[0]   <= '0;
            r_neg[0] <= r_neg0;
            r_ovf[0] <= CW'(r_n0) >= (CW'(r_d0) << QB);
        end
    end

    for (genvar s = 1; s <= QB; s++) begin : g_step
        localparam int K = QB - s;
        logic [CW-1:0] cmp;
        logic          ge;
        assign cmp = CW'(r_den[s-1]) << K;
        assign ge  = CW'(r_rem[s-1]) >= cmp;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= ge ? NW'(CW'(r_rem[s-1]) - cmp) : r_rem[s-1];
                r_den[s] <= r_den[s-1];
                r_q[s]   <= r_q[s-1] | (QB'(ge) << K);
                r_neg[s] <= r_neg[s-1];
                r_ovf[s] <= r_ovf[s-1];
            end
        end
    end

    // Round half away from zero on the magnitude, then saturate.
    assign rnd    = (CW'(r_rem[QB]) << 1) >= CW'(r_den[QB]);
    assign q_full = (W+1)'(r_q[QB]) + (W+1)'(rnd);

    always_comb begin
        if (!r_neg[QB]) begin
            n_quo = (r_ovf[QB] || q_full > MAXP) ? t_word'(MAXP[W-1:0])
                                                 : t_word'(q_full[W-1:0]);
        end else begin
            n_quo = (r_ovf[QB] || q_full > LIM) ? t_word'(LIM[W-1:0])
                                                : t_word'(-q_full[W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule
`default_nettype wire

### src/ami_divider.sv
`default_nettype none
// ============================================================================
// ami_divider: three divider lanes with the row tag and valid pipeline
// One result row enters per cycle while i_en is high; the tag travels beside the quotients.
// ============================================================================
module ami_divider (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  ami_pkg::t_meta  i_meta,
    input  ami_pkg::t_wide  i_num [3],
    input  ami_pkg::t_wide  i_den,
    input  logic            i_is_tr,
    output logic            o_valid,
    output ami_pkg::t_meta  o_meta,
    output ami_pkg::t_word  o_quo [3]
);
    import ami_pkg::*;

    logic [DS-1:0] r_v;
    t_meta         r_meta [DS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[DS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_meta[0] <= i_meta;
            for (int s = 1; s < DS; s++) begin
                r_meta[s] <= r_meta[s-1];
            end
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
        ami_div_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (i_en),
            .i_num   (i_num[j]),
            .i_den   (i_den),
            .i_is_tr (i_is_tr),
            .o_quo   (o_quo[j])
        );
    end

    assign o_valid = r_v[DS-1];
    assign o_meta  = r_meta[DS-1];

endmodule
`default_nettype wire

### src/affine_matrix_inverse.sv
`default_nettype none
// The first result row of a matrix passes the cofactor pipeline, the serializer
// register and the divider pipeline; the other three rows follow it back to back (no stall).
// A new matrix enters once per four result rows, set by the single row serializer that
// feeds the three divider lanes one result row per cycle while the output is not stalled.
// Reset (synchronous, active low) clears all valid bits and the serializer and
// sets the singular threshold to 7; data registers are not reset.
// ============================================================================
// affine_matrix_inverse: inverse of a 3x4 affine matrix in Q16.16
// Cofactor pipeline, row serializer and three pipelined dividers.
// ============================================================================
module affine_matrix_inverse (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  ami_pkg::t_word         i_rot_00,
    input  ami_pkg::t_word         i_rot_01,
    input  ami_pkg::t_word         i_rot_02,
    input  ami_pkg::t_word         i_rot_10,
    input  ami_pkg::t_word         i_rot_11,
    input  ami_pkg::t_word         i_rot_12,
    input  ami_pkg::t_word         i_rot_20,
    input  ami_pkg::t_word         i_rot_21,
    input  ami_pkg::t_word         i_rot_22,
    input  ami_pkg::t_word         i_shift_x,
    input  ami_pkg::t_word         i_shift_y,
    input  ami_pkg::t_word         i_shift_z,
    input  logic                   i_cfg_we,
    input  logic [ami_pkg::TW-1:0] i_cfg_wdata,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [ami_pkg::RB-1:0] o_row_index,
    output ami_pkg::t_word         o_col_a,
    output ami_pkg::t_word         o_col_b,
    output ami_pkg::t_word         o_col_c,
    output logic                   o_is_last,
    output logic                   o_singular
);
    import ami_pkg::*;

    // The whole pipeline moves as one whenever the output register is free or
    // being taken. The cofactor front end also waits while the serializer is
    // still sending rows 0 to 2 of the previous matrix.
    logic adv;
    logic front_adv;

    logic [TW-1:0] r_threshold;

    t_word s_in [4][3];

    logic  f_valid;
    t_adj  f_adj [3][3];
    t_wide f_tr [3];
    t_wide f_det;
    logic  f_sing;

    // Serializer: holds one matrix's numerators and emits one row per cycle unless stalled.
    logic          r_busy;
    logic [RB-1:0] r_row;
    t_adj          r_adj [3][3];
    t_wide         r_tr [3];
    t_wide         r_det;
    logic          r_sing;

    t_wide  d_num [3];
    t_wide  d_den;
    logic   d_is_tr;
    t_meta  d_meta;

    t_meta  q_meta;
    t_word  q_quo [3];

    assign adv       = !(o_valid && i_stall);
    assign front_adv = adv && (!r_busy || r_row == ROW_LAST);
    assign o_stall   = !front_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    assign s_in[0] = '{i_rot_00, i_rot_01, i_rot_02};
    assign s_in[1] = '{i_rot_10, i_rot_11, i_rot_12};
    assign s_in[2] = '{i_rot_20, i_rot_21, i_rot_22};
    assign s_in[3] = '{i_shift_x, i_shift_y, i_shift_z};

    ami_cofactor u_cof (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (front_adv),
        .i_valid     (i_valid),
        .i_s         (s_in),
        .i_threshold (r_threshold),
        .o_valid     (f_valid),
        .o_adj       (f_adj),
        .o_tr        (f_tr),
        .o_det       (f_det),
        .o_sing      (f_sing)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= ROW_0;
        end else if (front_adv) begin
            r_busy <= f_valid;
            r_row  <= ROW_0;
        end else if (adv && r_busy) begin
            r_row <= r_row + RB'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (front_adv) begin
            r_adj  <= f_adj;
            r_tr   <= f_tr;
            r_det  <= f_det;
            r_sing <= f_sing;
        end
    end

    // Row select. A singular matrix is sent as zero over one, so the dividers
    // return zero without a special path.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            case (r_row)
                ROW_0:   d_num[j] = t_wide'(r_adj[0][j]);
                ROW_1:   d_num[j] = t_wide'(r_adj[1][j]);
                ROW_2:   d_num[j] = t_wide'(r_adj[2][j]);
                default: d_num[j] = r_tr[j];
            endcase
            if (r_sing) begin
                d_num[j] = '0;
            end
        end
        d_den       = r_sing ? t_wide'(1) : r_det;
        d_is_tr     = r_row == ROW_LAST;
        d_meta.row  = r_row;
        d_meta.last = r_row == ROW_LAST;
        d_meta.sing = r_sing;
    end

    ami_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_busy),
        .i_meta  (d_meta),
        .i_num   (d_num),
        .i_den   (d_den),
        .i_is_tr (d_is_tr),
        .o_valid (o_valid),
        .o_meta  (q_meta),
        .o_quo   (q_quo)
    );

    assign o_row_index = q_meta.row;
    assign o_is_last   = q_meta.last;
    assign o_singular  = q_meta.sing;
    assign o_col_a     = q_quo[0];
    assign o_col_b     = q_quo[1];
    assign o_col_c     = q_quo[2];

    // The last flag marks the translation row and nothing else.
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_last == (o_row_index == ROW_LAST)))
        else $error("last flag and row index disagree");

    // A singular matrix delivers zeros in every column.
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> (o_col_a == '0 && o_col_b == '0 && o_col_c == '0))
        else $error("singular result carries nonzero values");

    // Rows of one matrix follow each other without a gap.
    a_row_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_is_last) |=>
            (o_valid && o_row_index == $past(o_row_index) + RB'(1)))
        else $error("result rows out of sequence");

    // The serializer only steps rows while it holds a matrix.
    a_ser_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_row != ROW_0) |-> $past(r_busy))
        else $error("serializer stepped while empty");

endmodule
`default_nettype wire
